// ----- rtl/rans_pkg.sv -----
// shared types and constants for the rans byte encoder
package rans_pkg;

  localparam int STATE_W        = 31;
  localparam int FREQ_W         = 13;
  localparam int START_W        = FREQ_W + 1;
  localparam int BYTE_W         = 8;
  localparam int FINAL_W        = 32;
  localparam int CFG_IDX_W      = 2;
  localparam int SCALE_BITS_DEF = 12;
  localparam int MAX_EMIT       = 2;

  localparam logic [STATE_W-1:0] LOWER_BOUND = STATE_W'(1) << 23;

  localparam logic [FREQ_W-1:0] FREQ_ZERO_RST = FREQ_W'(2048);
  localparam logic [FREQ_W-1:0] FREQ_ONE_RST  = FREQ_W'(2047);
  localparam logic [FREQ_W-1:0] FREQ_RUN_RST  = FREQ_W'(1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FREQ_ZERO = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FREQ_ONE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FREQ_RUN  = 2'd2;

  // request actions and symbols
  localparam logic ACT_ENCODE = 1'b0;
  localparam logic ACT_FINISH = 1'b1;

  localparam logic [1:0] SYM_ZERO = 2'd0;
  localparam logic [1:0] SYM_ONE  = 2'd1;
  localparam logic [1:0] SYM_RUN  = 2'd2;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic emit;
    logic finish;
    logic error;
    logic div_start;
    logic div_step;
    logic commit;
  } rans_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic is_finish;
    logic f_zero;
    logic emit_go;
    logic div_done;
    logic out_free;
  } rans_stat_t;

endpackage

// ----- rtl/rans_ctrl.sv -----
// controller state machine for the rans byte encoder
module rans_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rans_pkg::rans_stat_t stat,
  output rans_pkg::rans_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_COMMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // next state and command decode
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.is_finish) begin
          if (stat.out_free) begin
            cmd.finish = 1'b1;
            state_nxt  = S_IDLE;
          end
        end else if (stat.f_zero) begin
          if (stat.out_free) begin
            cmd.error = 1'b1;
            state_nxt = S_IDLE;
          end
        end else if (stat.emit_go) begin
          if (stat.out_free) begin
            cmd.emit = 1'b1;
          end
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/rans_dp.sv -----
// datapath: frequency registers, coder state, renormalization, divider, result register
module rans_dp #(
  parameter int SCALE_BITS = rans_pkg::SCALE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_action,
  input  logic [1:0]                         in_symbol,
  input  logic                               cfg_valid,
  input  logic [rans_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rans_pkg::FREQ_W-1:0]        cfg_data,
  input  rans_pkg::rans_cmd_t                cmd,
  output rans_pkg::rans_stat_t               stat,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [rans_pkg::BYTE_W-1:0]        out_byte,
  output logic [rans_pkg::FINAL_W-1:0]       out_final_state,
  output logic                               out_is_final,
  output logic                               out_coding_error,
  output logic                               out_last
);

  localparam int SW     = rans_pkg::STATE_W;
  localparam int FW     = rans_pkg::FREQ_W;
  localparam int SHIFT  = SW - SCALE_BITS;
  localparam int CNT_W  = $clog2(SW);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(SW - 1);

  logic [FW-1:0]                  freq_zero_r;
  logic [FW-1:0]                  freq_one_r;
  logic [FW-1:0]                  freq_run_r;
  logic [SW-1:0]                  state_r;
  logic                           act_r;
  logic [FW-1:0]                  f_r;
  logic [rans_pkg::START_W-1:0]   start_r;
  logic [SW-1:0]                  x_r;
  logic [FW-1:0]                  rem_r;
  logic [CNT_W-1:0]               cnt_r;
  logic [1:0]                     emit_cnt_r;

  logic                           out_valid_r;
  logic [rans_pkg::BYTE_W-1:0]    byte_r;
  logic [rans_pkg::FINAL_W-1:0]   final_r;
  logic                           is_final_r;
  logic                           err_r;
  logic                           last_r;

  logic [FW-1:0]                  f_sel;
  logic [rans_pkg::START_W-1:0]   start_sel;
  logic                           ge0;
  logic                           ge1;
  logic                           emit_last;
  logic [FW:0]                    rem_sh;
  logic                           q_bit;
  logic [FW-1:0]                  rem_nxt;
  logic [SW-1:0]                  state_nxt;

  // symbol lookup of frequency and start
  always_comb begin
    case (in_symbol)
      rans_pkg::SYM_ZERO: begin
        f_sel     = freq_zero_r;
        start_sel = '0;
      end
      rans_pkg::SYM_ONE: begin
        f_sel     = freq_one_r;
        start_sel = rans_pkg::START_W'(freq_zero_r);
      end
      rans_pkg::SYM_RUN: begin
        f_sel     = freq_run_r;
        start_sel = rans_pkg::START_W'(freq_zero_r) + rans_pkg::START_W'(freq_one_r);
      end
      default: begin
        f_sel     = '0;
        start_sel = '0;
      end
    endcase
  end

  // renormalization tests: x >= f << SHIFT, now and after one byte out
  assign ge0       = (x_r >> SHIFT) >= SW'(f_r);
  assign ge1       = (x_r >> (SHIFT + 8)) >= SW'(f_r);
  assign emit_last = (emit_cnt_r == 2'(rans_pkg::MAX_EMIT - 1)) || !ge1;

  // one restoring division step
  assign rem_sh  = {rem_r, x_r[SW-1]};
  assign q_bit   = rem_sh >= {1'b0, f_r};
  assign rem_nxt = q_bit ? FW'(rem_sh - {1'b0, f_r}) : FW'(rem_sh);

  // coding step after division: x_r holds quotient
  assign state_nxt = (x_r << SCALE_BITS) + SW'(rem_r) + SW'(start_r);

  assign stat.is_finish = (act_r == rans_pkg::ACT_FINISH);
  assign stat.f_zero    = (f_r == '0);
  assign stat.emit_go   = ge0 && (emit_cnt_r != 2'(rans_pkg::MAX_EMIT));
  assign stat.div_done  = (cnt_r == LAST_STEP);
  assign stat.out_free  = !out_valid_r || out_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_zero_r <= rans_pkg::FREQ_ZERO_RST;
      freq_one_r  <= rans_pkg::FREQ_ONE_RST;
      freq_run_r  <= rans_pkg::FREQ_RUN_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        rans_pkg::CFG_FREQ_ZERO: freq_zero_r <= cfg_data;
        rans_pkg::CFG_FREQ_ONE:  freq_one_r  <= cfg_data;
        rans_pkg::CFG_FREQ_RUN:  freq_run_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // coder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rans_pkg::LOWER_BOUND;
    end else if (cmd.finish) begin
      state_r <= rans_pkg::LOWER_BOUND;
    end else if (cmd.commit) begin
      state_r <= state_nxt;
    end
  end

  // working registers for the current request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_cnt_r <= '0;
      cnt_r      <= '0;
    end else begin
      if (cmd.load) begin
        emit_cnt_r <= '0;
      end else if (cmd.emit) begin
        emit_cnt_r <= emit_cnt_r + 2'd1;
      end
      if (cmd.div_start) begin
        cnt_r <= '0;
      end else if (cmd.div_step) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r   <= in_action;
      f_r     <= f_sel;
      start_r <= start_sel;
      x_r     <= state_r;
    end else if (cmd.emit) begin
      x_r <= x_r >> 8;
    end else if (cmd.div_step) begin
      x_r <= {x_r[SW-2:0], q_bit};
    end
    if (cmd.div_start) begin
      rem_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit || cmd.finish || cmd.error) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit || cmd.finish || cmd.error) begin
      byte_r     <= cmd.emit ? x_r[rans_pkg::BYTE_W-1:0] : '0;
      final_r    <= cmd.finish ? {1'b0, state_r} : '0;
      is_final_r <= cmd.finish;
      err_r      <= cmd.error;
      last_r     <= cmd.emit ? emit_last : 1'b1;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = byte_r;
  assign out_final_state  = final_r;
  assign out_is_final     = is_final_r;
  assign out_coding_error = err_r;
  assign out_last         = last_r;

endmodule

// ----- rtl/rans_byte_encoder.sv -----
// top level of the byte-wise rans encoder
// encode request: capture, check, 0 to 2 low bytes flushed as the output frees,
//   a bit-serial restoring division of the 31-bit state, then a commit state
// finish or zero-frequency request: result set from the check state once the output is free
// one request in flight at a time; a waiting result does not block taking the next request
// synchronous active-low reset: coder state 2^23, frequencies 2048, 2047 and 1
module rans_byte_encoder #(
  parameter int SCALE_BITS = rans_pkg::SCALE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_action,
  input  logic [1:0]                     in_symbol,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [rans_pkg::BYTE_W-1:0]    out_byte,
  output logic [rans_pkg::FINAL_W-1:0]   out_final_state,
  output logic                           out_is_final,
  output logic                           out_coding_error,
  output logic                           out_last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rans_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rans_pkg::FREQ_W-1:0]    cfg_data
);

  rans_pkg::rans_cmd_t  cmd;
  rans_pkg::rans_stat_t stat;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  // sequencer
  rans_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // arithmetic and storage
  rans_dp #(
    .SCALE_BITS (SCALE_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_action        (in_action),
    .in_symbol        (in_symbol),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_final_state  (out_final_state),
    .out_is_final     (out_is_final),
    .out_coding_error (out_coding_error),
    .out_last         (out_last)
  );

endmodule

// ----- rtl/rans_chk.sv -----
// port-level checker for the rans byte encoder, with its bind
module rans_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [rans_pkg::BYTE_W-1:0]    out_byte,
  input logic [rans_pkg::FINAL_W-1:0]   out_final_state,
  input logic                           out_is_final,
  input logic                           out_coding_error,
  input logic                           out_last
);

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
      $stable(out_final_state) && $stable(out_last))
    else $error("result changed while stalled");

  // final state and error results close their request and carry no byte
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_is_final || out_coding_error) |->
      out_last && out_byte == '0 && !(out_is_final && out_coding_error))
    else $error("final or error result malformed");

  // final state field is zero unless the result is final
  a_final_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_final |-> out_final_state == '0)
    else $error("final state set on a non-final result");

  // one request at a time: ready drops after a request is taken
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");

endmodule

bind rans_byte_encoder rans_chk u_chk (.*);

// ----- bench/tb_rans_byte_encoder.sv -----
// self-checking testbench for the byte-wise rans encoder
`timescale 1ns / 100ps

module tb_rans_byte_encoder;

  localparam int SCALE           = rans_pkg::SCALE_BITS_DEF;
  localparam int SETTLE          = 40;      // covers the slowest symbol
  localparam int HOLD_CYCLES     = 300;
  localparam int CYCLE_LIMIT     = 500000;
  localparam int NUM_PHASES      = 7;
  localparam int ITEMS_PER_PHASE = 90;
  localparam int HOLD_PHASE      = 3;
  localparam int MAX_REPORTS     = 40;

  // symbol code with no frequency, and the register index with no register
  localparam logic [1:0]                     SYM_NONE   = 2'd3;
  localparam logic [rans_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [rans_pkg::BYTE_W-1:0]  byte_val;
    logic [rans_pkg::FINAL_W-1:0] state_val;
    logic                         is_final;
    logic                         coding_error;
    logic                         last;
  } rans_result_t;

  typedef enum logic [1:0] {ROW_REQ, ROW_REQ_TYPED, ROW_CFG} row_kind_t;

  // one line of the directed table: a request, a request with its result, or a register write
  typedef struct packed {
    row_kind_t                   kind;
    logic                        act;
    logic [1:0]                  sel;
    logic [rans_pkg::FREQ_W-1:0] data;
    rans_result_t                res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_action = rans_pkg::ACT_ENCODE;
  logic [1:0] in_symbol = rans_pkg::SYM_ZERO;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [rans_pkg::BYTE_W-1:0] out_byte;
  logic [rans_pkg::FINAL_W-1:0] out_final_state;
  logic out_is_final;
  logic out_coding_error;
  logic out_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [rans_pkg::CFG_IDX_W-1:0] cfg_index = rans_pkg::CFG_FREQ_ZERO;
  logic [rans_pkg::FREQ_W-1:0] cfg_data = '0;

  // predictor state: coder state and symbol frequencies
  logic [rans_pkg::STATE_W-1:0] coded_state = rans_pkg::LOWER_BOUND;
  logic [rans_pkg::FREQ_W-1:0]  sym_freq [3] = '{rans_pkg::FREQ_ZERO_RST,
                                                 rans_pkg::FREQ_ONE_RST,
                                                 rans_pkg::FREQ_RUN_RST};

  rans_result_t pending_results[$];
  dir_row_t     dir_rows[$];

  int  cycle_count    = 0;
  int  mismatch_count = 0;
  int  n_requests     = 0;
  int  n_bytes        = 0;
  int  n_finals       = 0;
  int  n_errors       = 0;
  int  n_settings     = 1;
  bit  hold_off       = 1'b0;
  bit  drain_fast     = 1'b0;

  rans_byte_encoder DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_symbol        (in_symbol),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_final_state  (out_final_state),
    .out_is_final     (out_is_final),
    .out_coding_error (out_coding_error),
    .out_last         (out_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycle_count, pending_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  // works out the results of one request and advances the coder state
  function automatic void code_symbol(input logic act, input logic [1:0] sym, input bit keep);
    rans_result_t                r;
    logic [rans_pkg::FREQ_W-1:0] f;
    logic [63:0]                 start;
    logic [63:0]                 x;
    logic [63:0]                 bound;
    logic [63:0]                 nxt;
    int                          n;
    r = '0;
    if (act == rans_pkg::ACT_FINISH) begin
      r.state_val = {1'b0, coded_state};
      r.is_final  = 1'b1;
      r.last      = 1'b1;
      if (keep) pending_results.push_back(r);
      coded_state = rans_pkg::LOWER_BOUND;
      return;
    end
    case (sym)
      rans_pkg::SYM_ZERO: begin f = sym_freq[0]; start = 64'd0; end
      rans_pkg::SYM_ONE:  begin f = sym_freq[1]; start = 64'(sym_freq[0]); end
      rans_pkg::SYM_RUN:  begin
        f     = sym_freq[2];
        start = 64'(sym_freq[0]) + 64'(sym_freq[1]);
      end
      default:  begin f = '0; start = 64'd0; end
    endcase
    // zero frequency: error result, state kept
    if (f == '0) begin
      r.coding_error = 1'b1;
      r.last         = 1'b1;
      if (keep) pending_results.push_back(r);
      return;
    end
    // flush low bytes while the state is too large for this symbol
    bound = ((64'(rans_pkg::LOWER_BOUND) >> SCALE) << 8) * 64'(f);
    x = 64'(coded_state);
    n = 0;
    while (x >= bound && n < rans_pkg::MAX_EMIT) begin
      r          = '0;
      r.byte_val = x[7:0];
      x          = x >> 8;
      n++;
      r.last     = !(x >= bound && n < rans_pkg::MAX_EMIT);
      if (keep) pending_results.push_back(r);
    end
    nxt = ((x / 64'(f)) << SCALE) + (x % 64'(f)) + start;
    coded_state = nxt[rans_pkg::STATE_W-1:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
  endtask

  // result checker
  always @(posedge clk) begin : result_check
    rans_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with none expected, byte", 32'(out_byte), 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_byte !== want.byte_val)
          report_mismatch("out_byte", 32'(out_byte), 32'(want.byte_val));
        if (out_final_state !== want.state_val)
          report_mismatch("out_final_state", out_final_state, want.state_val);
        if (out_is_final !== want.is_final)
          report_mismatch("out_is_final", 32'(out_is_final), 32'(want.is_final));
        if (out_coding_error !== want.coding_error)
          report_mismatch("out_coding_error", 32'(out_coding_error),
                          32'(want.coding_error));
        if (out_last !== want.last)
          report_mismatch("out_last", 32'(out_last), 32'(want.last));
        if (want.is_final) n_finals++;
        else if (want.coding_error) n_errors++;
        else n_bytes++;
      end
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin : receiver
    @(posedge clk);
    forever begin
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
      end else if (!drain_fast && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  // offers one request and updates the predictor when it is taken
  task automatic send_request(input logic act, input logic [1:0] sym, input bit typed,
                              input rans_result_t typed_res, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_action <= act;
    in_symbol <= sym;
    do @(posedge clk); while (!in_ready);
    if (typed) begin
      pending_results.push_back(typed_res);
      code_symbol(act, sym, 1'b0);
    end else begin
      code_symbol(act, sym, 1'b1);
    end
    n_requests++;
  endtask

  // register write, only once the block has gone quiet
  task automatic write_register(input logic [rans_pkg::CFG_IDX_W-1:0] idx,
                                input logic [rans_pkg::FREQ_W-1:0] val);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      rans_pkg::CFG_FREQ_ZERO: sym_freq[0] = val;
      rans_pkg::CFG_FREQ_ONE:  sym_freq[1] = val;
      rans_pkg::CFG_FREQ_RUN:  sym_freq[2] = val;
      default: ;
    endcase
  endtask

  function automatic dir_row_t req(input logic act, input logic [1:0] sym);
    return '{ROW_REQ, act, sym, '0, '0};
  endfunction

  function automatic dir_row_t req_fin(input logic [rans_pkg::STATE_W-1:0] st);
    return '{ROW_REQ_TYPED, rans_pkg::ACT_FINISH, rans_pkg::SYM_ZERO, '0,
             '{8'd0, {1'b0, st}, 1'b1, 1'b0, 1'b1}};
  endfunction

  function automatic dir_row_t req_err(input logic [1:0] sym);
    return '{ROW_REQ_TYPED, rans_pkg::ACT_ENCODE, sym, '0,
             '{8'd0, 32'd0, 1'b0, 1'b1, 1'b1}};
  endfunction

  function automatic dir_row_t wr(input logic [rans_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [rans_pkg::FREQ_W-1:0] val);
    return '{ROW_CFG, rans_pkg::ACT_ENCODE, idx, val, '0};
  endfunction

  // stimulus
  initial begin : sender
    dir_row_t   row;
    logic       act;
    logic [1:0] sym;
    int         gap;
    int         pick;
    int         f0;
    int         f1;
    int         f2;
    bit         idle_now;

    // directed part: reset state, renormalization of 0, 1 and 2 bytes, errors, extremes
    dir_rows.push_back(req_fin(rans_pkg::LOWER_BOUND));
    dir_rows.push_back(req_err(SYM_NONE));
    dir_rows.push_back(req(rans_pkg::ACT_ENCODE, rans_pkg::SYM_ZERO));
    dir_rows.push_back(req(rans_pkg::ACT_ENCODE, rans_pkg::SYM_RUN));
    dir_rows.push_back(req(rans_pkg::ACT_ENCODE, rans_pkg::SYM_RUN));
    dir_rows.push_back(req(rans_pkg::ACT_ENCODE, rans_pkg::SYM_ONE));
    dir_rows.push_back(req(rans_pkg::ACT_FINISH, SYM_NONE));
    dir_rows.push_back(req_fin(rans_pkg::LOWER_BOUND));
    dir_rows.push_back(wr(rans_pkg::CFG_FREQ_ONE, 13'd0));
    dir_rows.push_back(req_err(rans_pkg::SYM_ONE));
    dir_rows.push_back(req(rans_pkg::ACT_ENCODE, rans_pkg::SYM_ZERO));
    dir_rows.push_back(req(rans_pkg::ACT_ENCODE, rans_pkg::SYM_RUN));
    dir_rows.push_back(wr(rans_pkg::CFG_FREQ_ZERO, 13'd4096));
    dir_rows.push_back(wr(rans_pkg::CFG_FREQ_RUN, 13'd0));
    dir_rows.push_back(req(rans_pkg::ACT_ENCODE, rans_pkg::SYM_ZERO));
    dir_rows.push_back(req_err(rans_pkg::SYM_RUN));
    dir_rows.push_back(req_err(rans_pkg::SYM_ONE));
    dir_rows.push_back(wr(rans_pkg::CFG_FREQ_ZERO, 13'h1fff));
    dir_rows.push_back(wr(rans_pkg::CFG_FREQ_ONE, 13'h1fff));
    dir_rows.push_back(wr(rans_pkg::CFG_FREQ_RUN, 13'h1fff));
    dir_rows.push_back(req(rans_pkg::ACT_ENCODE, rans_pkg::SYM_ZERO));
    dir_rows.push_back(req(rans_pkg::ACT_ENCODE, rans_pkg::SYM_ONE));
    dir_rows.push_back(req(rans_pkg::ACT_ENCODE, rans_pkg::SYM_RUN));
    dir_rows.push_back(req(rans_pkg::ACT_FINISH, rans_pkg::SYM_ONE));
    dir_rows.push_back(wr(CFG_UNUSED, 13'h1555));
    dir_rows.push_back(req(rans_pkg::ACT_ENCODE, rans_pkg::SYM_RUN));
    dir_rows.push_back(req(rans_pkg::ACT_FINISH, rans_pkg::SYM_RUN));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.kind == ROW_CFG) begin
        write_register(row.sel, row.data);
        n_settings++;
      end else begin
        send_request(row.act, row.sel, row.kind == ROW_REQ_TYPED, row.res,
                     $urandom_range(0, 1) ? 0 : $urandom_range(1, 19));
      end
    end

    // random part: one frequency setting per phase
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin f0 = 2048; f1 = 2047; f2 = 1;    end
        1: begin f0 = 1365; f1 = 1365; f2 = 1366; end
        2: begin f0 = 1;    f1 = 1;    f2 = 4094; end
        4: begin f0 = 0;    f1 = 4096; f2 = 0;    end
        5: begin
          f0 = $urandom_range(0, 8191);
          f1 = $urandom_range(0, 8191);
          f2 = $urandom_range(0, 8191);
        end
        default: begin
          f0 = $urandom_range(1, 4094);
          f1 = $urandom_range(1, 4095 - f0);
          f2 = 4096 - f0 - f1;
        end
      endcase
      write_register(rans_pkg::CFG_FREQ_ZERO, f0[rans_pkg::FREQ_W-1:0]);
      write_register(rans_pkg::CFG_FREQ_ONE, f1[rans_pkg::FREQ_W-1:0]);
      write_register(rans_pkg::CFG_FREQ_RUN, f2[rans_pkg::FREQ_W-1:0]);
      n_settings++;
      if (ph == NUM_PHASES - 1) drain_fast = 1'b1;
      idle_now = 1'b0;

      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (k % 16 == 0) idle_now = ($urandom_range(0, 3) != 0);
        if (ph == HOLD_PHASE && k == 20) hold_off = 1'b1;
        // back-to-back requests while held off, when draining or busy, and at random
        if (drain_fast || !idle_now || (ph == HOLD_PHASE && k >= 20 && k < 60) ||
            $urandom_range(0, 2) != 0)
          gap = 0;
        else
          gap = $urandom_range(1, 19);
        // mostly symbol runs closed by a finish, a few invalid symbols
        pick = $urandom_range(0, 39);
        if (pick < 2) begin
          act = rans_pkg::ACT_FINISH;
          sym = 2'($urandom_range(0, 3));
        end else begin
          act = rans_pkg::ACT_ENCODE;
          sym = (pick == 2) ? SYM_NONE : 2'($urandom_range(0, 2));
        end
        send_request(act, sym, 1'b0, '0, gap);
      end
    end

    // drain
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("ran %0d requests over %0d frequency settings in %0d cycles",
             n_requests, n_settings, cycle_count);
    $display("checked %0d flushed bytes, %0d final states, %0d zero-frequency errors",
             n_bytes, n_finals, n_errors);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/rans_pkg.sv
rtl/rans_ctrl.sv
rtl/rans_dp.sv
rtl/rans_byte_encoder.sv
rtl/rans_chk.sv
bench/tb_rans_byte_encoder.sv
